>>> hw/rtl/owrb_pkg.sv
// owrb_pkg: shared widths and action codes for the overwrite ring buffer
// no dependencies; imported by owrb_mem and overwrite_ring_buffer_core
package owrb_pkg;

	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 6;
	localparam int ACTION_W = 2;

	localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_DRAIN = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd3;

endpackage

>>> hw/rtl/owrb_mem.sv
// owrb_mem: byte storage of the ring, one write port and one read port
// read data is registered and holds until the next read; uses owrb_pkg
module owrb_mem
	import owrb_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [BYTE_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem_q [DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/overwrite_ring_buffer_core.sv
// overwrite_ring_buffer_core: byte ring buffer that drops the oldest byte when full
// write and empty-read results are loaded into the output register at the beat
// a byte read passes the memory read register, then the output register; a drain
// of n bytes streams one byte per cycle when the output is not stalled, as set by
// the single memory read port; arst_n clears head, tail, control and output valid;
// byte storage is not cleared; uses owrb_pkg and owrb_mem
module overwrite_ring_buffer_core
	import owrb_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // write_data
	input  logic [1:0]  s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // read_byte, frame_length, 2'b0 pad
	output logic        m_axis_tlast,  // is_last
	output logic [1:0]  m_axis_tuser   // was_empty, dropped_oldest
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = (IW > LEN_W) ? IW : LEN_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [IW:0]   DEPTH_EXT = (IW + 1)'(DEPTH);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	logic              state_q;
	logic [IW-1:0]     head_q;
	logic [IW-1:0]     tail_q;
	logic [IW-1:0]     rem_q;
	logic [LEN_W-1:0]  len_q;
	logic              pend_q;
	logic              pend_last_q;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [LEN_W-1:0]  out_len_q;
	logic              out_last_q;
	logic              out_empty_q;
	logic              out_drop_q;

	logic              slot_free;
	logic              in_fire;
	logic              out_fire;
	logic              consume;
	logic              issue;
	logic [IW-1:0]     head_inc;
	logic [IW-1:0]     tail_inc;
	logic              is_empty;
	logic [IW:0]       diff;
	logic [IW-1:0]     count;
	logic [LW-1:0]     count_ext;
	logic [LEN_W-1:0]  count_len;
	logic              mem_we;
	logic [BYTE_W-1:0] mem_rdata;

	assign slot_free     = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && slot_free;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_fire      = out_valid_q && m_axis_tready;

	assign consume = (state_q == ST_BUSY) && pend_q && slot_free;
	assign issue   = (state_q == ST_BUSY) && (rem_q != '0) && (!pend_q || consume);

	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign is_empty = (head_q == tail_q);

	always_comb begin
		diff = {1'b0, tail_q} - {1'b0, head_q};
		if (tail_q < head_q) begin
			diff = diff + DEPTH_EXT;
		end
		count     = diff[IW-1:0];
		count_ext = LW'(count);
		count_len = count_ext[LEN_W-1:0];
	end

	assign mem_we = in_fire && (s_axis_tuser == ACT_WRITE);

	owrb_mem #(
		.DEPTH (DEPTH),
		.AW    (IW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (tail_q),
		.wdata (s_axis_tdata),
		.re    (issue),
		.raddr (head_q),
		.rdata (mem_rdata)
	);

	// control and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			rem_q       <= '0;
			len_q       <= '0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						unique case (s_axis_tuser)
							ACT_WRITE: begin
								tail_q <= tail_inc;
								if (tail_inc == head_q) begin
									head_q <= head_inc;
								end
							end
							ACT_READ: begin
								if (!is_empty) begin
									rem_q   <= IW'(1);
									len_q   <= '0;
									state_q <= ST_BUSY;
								end
							end
							ACT_DRAIN: begin
								if (!is_empty) begin
									rem_q   <= count;
									len_q   <= count_len;
									state_q <= ST_BUSY;
								end
							end
							ACT_NONE: begin
							end
							default: begin
							end
						endcase
					end
				end
				ST_BUSY: begin
					if (issue) begin
						head_q      <= head_inc;
						rem_q       <= rem_q - 1'b1;
						pend_last_q <= (rem_q == IW'(1));
						pend_q      <= 1'b1;
					end else if (consume) begin
						pend_q <= 1'b0;
					end
					if (consume && pend_last_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume) begin
			out_valid_q <= 1'b1;
		end else if (in_fire && (s_axis_tuser != ACT_NONE) &&
				((s_axis_tuser == ACT_WRITE) || is_empty)) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			out_byte_q  <= mem_rdata;
			out_len_q   <= len_q;
			out_last_q  <= pend_last_q;
			out_empty_q <= 1'b0;
			out_drop_q  <= 1'b0;
		end else if (in_fire) begin
			out_byte_q  <= '0;
			out_len_q   <= '0;
			out_last_q  <= 1'b1;
			out_empty_q <= (s_axis_tuser != ACT_WRITE) && is_empty;
			out_drop_q  <= (s_axis_tuser == ACT_WRITE) && (tail_inc == head_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_len_q, out_byte_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = {out_drop_q, out_empty_q};

endmodule

>>> sim/tb_overwrite_ring_buffer_core.sv
// tb_overwrite_ring_buffer_core: self-checking bench for the overwriting byte ring buffer
// drives write, read and drain commands with random idling and checks every output beat
// depends on owrb_pkg and overwrite_ring_buffer_core
module tb_overwrite_ring_buffer_core;
	import owrb_pkg::*;

	localparam int DEPTH = 64;

	typedef struct {
		logic [ACTION_W-1:0] action;
		logic [BYTE_W-1:0]   data;
		bit                  wait_idle;
	} ring_cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_byte;
		logic [LEN_W-1:0]  frame_length;
		logic              is_last;
		logic              was_empty;
		logic              dropped_oldest;
	} ring_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = ACT_NONE;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [1:0]  m_axis_tuser;

	ring_cmd_t cmd_backlog[$];
	ring_out_t out_owed[$];

	logic [BYTE_W-1:0] shadow_bytes [DEPTH];
	logic [LEN_W-1:0]  shadow_head = '0;
	logic [LEN_W-1:0]  shadow_tail = '0;

	int mismatches = 0;
	int beats_in = 0;
	int outs_seen = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;

	overwrite_ring_buffer_core #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	always #2 clk = ~clk;

	task automatic ring_apply_cmd(input logic [ACTION_W-1:0] action,
			input logic [BYTE_W-1:0] data);
		ring_out_t r;
		logic [LEN_W-1:0] n;
		r = '0;
		r.is_last = 1'b1;
		case (action)
			ACT_WRITE: begin
				shadow_bytes[shadow_tail] = data;
				shadow_tail = shadow_tail + 1'b1;
				if (shadow_tail == shadow_head) begin
					shadow_head = shadow_head + 1'b1;
					r.dropped_oldest = 1'b1;
				end
				out_owed.push_back(r);
			end
			ACT_READ: begin
				if (shadow_head == shadow_tail) begin
					r.was_empty = 1'b1;
				end else begin
					r.read_byte = shadow_bytes[shadow_head];
					shadow_head = shadow_head + 1'b1;
				end
				out_owed.push_back(r);
			end
			ACT_DRAIN: begin
				n = shadow_tail - shadow_head;
				if (n == 0) begin
					r.was_empty = 1'b1;
					out_owed.push_back(r);
				end else begin
					for (int k = 0; k < n; k++) begin
						r.read_byte    = shadow_bytes[shadow_head];
						r.frame_length = n;
						r.is_last      = (k + 1 == n);
						out_owed.push_back(r);
						shadow_head = shadow_head + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic push_cmd(input logic [ACTION_W-1:0] action, input int data,
			input bit wait_idle = 1'b0);
		ring_cmd_t c;
		c.action    = action;
		c.data      = data[7:0];
		c.wait_idle = wait_idle;
		cmd_backlog.push_back(c);
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= ACT_NONE;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				ring_apply_cmd(s_axis_tuser, s_axis_tdata);
				beats_in++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (cmd_backlog.size() == 0 ||
						(cmd_backlog[0].wait_idle && out_owed.size() != 0)) begin
					s_axis_tvalid <= 1'b0;
				end else begin
					s_axis_tvalid <= 1'b1;
					s_axis_tuser  <= cmd_backlog[0].action;
					s_axis_tdata  <= cmd_backlog[0].data;
					void'(cmd_backlog.pop_front());
					gap_left = ((beats_in / 24) % 4 == 1) ? 0 : $urandom_range(0, 3);
				end
			end
		end
	end

	// output monitor and receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (out_owed.size() == 0) begin
					$error("unexpected output beat: tdata %h tlast %b tuser %b",
						m_axis_tdata, m_axis_tlast, m_axis_tuser);
					mismatches++;
				end else begin
					check_field("read_byte", out_owed[0].read_byte, m_axis_tdata[7:0]);
					check_field("frame_length", out_owed[0].frame_length,
						m_axis_tdata[13:8]);
					check_field("is_last", out_owed[0].is_last, m_axis_tlast);
					check_field("was_empty", out_owed[0].was_empty, m_axis_tuser[0]);
					check_field("dropped_oldest", out_owed[0].dropped_oldest,
						m_axis_tuser[1]);
					void'(out_owed.pop_front());
				end
				outs_seen++;
				if (outs_seen == 200)
					hold_left = 400;
				else
					stall_left = ((outs_seen / 32) % 4 == 2) ? 0 : $urandom_range(0, 3);
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		int issued;
		int pick;
		int len;

		// empty cases, ignored code, data extremes, short frames
		push_cmd(ACT_DRAIN, 8'h00);
		push_cmd(ACT_READ, 8'hFF);
		push_cmd(ACT_NONE, 8'hFF);
		push_cmd(ACT_WRITE, 8'h00);
		push_cmd(ACT_WRITE, 8'hFF);
		push_cmd(ACT_WRITE, 8'hA5);
		push_cmd(ACT_WRITE, 8'h5A);
		push_cmd(ACT_READ, 8'h00);
		push_cmd(ACT_DRAIN, 8'hFF);
		push_cmd(ACT_READ, 8'h00);
		push_cmd(ACT_WRITE, 8'h01);
		push_cmd(ACT_DRAIN, 8'h00);
		push_cmd(ACT_DRAIN, 8'h00);
		push_cmd(ACT_WRITE, 8'h80);
		push_cmd(ACT_WRITE, 8'h7F);
		push_cmd(ACT_READ, 8'h00);
		push_cmd(ACT_READ, 8'h00);
		push_cmd(ACT_READ, 8'h00);
		push_cmd(ACT_NONE, 8'h00);

		// fill past capacity so the oldest bytes get dropped, then a full frame
		push_cmd(ACT_WRITE, $urandom_range(0, 255), 1'b1);
		repeat (69) push_cmd(ACT_WRITE, $urandom_range(0, 255));
		push_cmd(ACT_DRAIN, $urandom_range(0, 255));
		issued = 71;
		while (issued < 200) begin
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 75)
					: $urandom_range(1, 8);
				repeat (len) push_cmd(ACT_WRITE, $urandom_range(0, 255));
				issued += len;
			end else if (pick < 7) begin
				len = $urandom_range(1, 4);
				repeat (len) push_cmd(ACT_READ, $urandom_range(0, 255));
				issued += len;
			end else if (pick < 9) begin
				push_cmd(ACT_DRAIN, $urandom_range(0, 255));
				issued++;
			end else begin
				push_cmd(ACT_NONE, $urandom_range(0, 255));
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (out_owed.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (mismatches == 0)
			$display("tb_overwrite_ring_buffer_core: done, clean");
		else
			$display("tb_overwrite_ring_buffer_core: done, errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_overwrite_ring_buffer_core: done, errors");
		$finish;
	end

endmodule
